/* src/stack_bytecode_executor_core_defines.svh */
// Assertion macros shared by the stack executor RTL.
`ifndef STACK_BYTECODE_EXECUTOR_CORE_DEFINES_SVH
`define STACK_BYTECODE_EXECUTOR_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SBE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SBE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SBE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* src/sbe_pkg.sv */
// Shared types and constants of the stack executor.
package sbe_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DEPTH_F_W   = 5;
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int IN_W        = 40;
    localparam int OUT_W       = 72;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH_CONST = 3'd0,
        OP_PUSH_ACC   = 3'd1,
        OP_POP_ACC    = 3'd2,
        OP_ADD        = 3'd3,
        OP_MUL        = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef struct packed {
        logic              fire;
        func_t             func;
        logic [DATA_W-1:0] push_data;
    } stack_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] cur_top;
        logic [DATA_W-1:0] top;
        logic [CNT_W-1:0]  depth;
        status_t           status;
    } stack_view_t;

endpackage

/* src/sbe_stack.sv */
// Operand stack held as a shift line of registers, top entry at index 0.
`include "stack_bytecode_executor_core_defines.svh"
module sbe_stack
(
    input  logic                clk,
    input  logic                rst_n,
    input  sbe_pkg::stack_cmd_t cmd,
    output sbe_pkg::stack_view_t view
);

    logic [sbe_pkg::DATA_W-1:0] stack_reg  [sbe_pkg::STACK_DEPTH];
    logic [sbe_pkg::DATA_W-1:0] stack_next [sbe_pkg::STACK_DEPTH];
    logic [sbe_pkg::CNT_W-1:0]  depth_reg;
    logic [sbe_pkg::CNT_W-1:0]  depth_next;
    logic [sbe_pkg::DATA_W-1:0] comb_result;
    logic                       is_full;
    logic                       is_empty;
    logic                       below_two;
    logic                       do_push;
    logic                       do_pop;
    logic                       do_comb;
    sbe_pkg::status_t           status;

    assign is_full   = (depth_reg == sbe_pkg::CNT_W'(sbe_pkg::STACK_DEPTH));
    assign is_empty  = (depth_reg == '0);
    assign below_two = (depth_reg < sbe_pkg::CNT_W'(2));

    assign comb_result = (cmd.func == sbe_pkg::OP_MUL) ? (stack_reg[0] * stack_reg[1])
                                                       : (stack_reg[0] + stack_reg[1]);

    always_comb
    begin
        status  = sbe_pkg::ST_OK;
        do_push = 1'b0;
        do_pop  = 1'b0;
        do_comb = 1'b0;
        case (cmd.func)
            sbe_pkg::OP_PUSH_CONST,
            sbe_pkg::OP_PUSH_ACC:
            begin
                if (is_full)
                    status = sbe_pkg::ST_OVERFLOW;
                else
                    do_push = 1'b1;
            end
            sbe_pkg::OP_POP_ACC:
            begin
                if (is_empty)
                    status = sbe_pkg::ST_UNDERFLOW;
                else
                    do_pop = 1'b1;
            end
            sbe_pkg::OP_ADD,
            sbe_pkg::OP_MUL:
            begin
                if (below_two)
                    status = sbe_pkg::ST_UNDERFLOW;
                else
                    do_comb = 1'b1;
            end
            default:
            begin
                status = sbe_pkg::ST_OK;
            end
        endcase
    end

    for (genvar i = 0; i < sbe_pkg::STACK_DEPTH; i++)
    begin : g_entry
        logic [sbe_pkg::DATA_W-1:0] shift_dn;
        logic [sbe_pkg::DATA_W-1:0] shift_up;
        logic [sbe_pkg::DATA_W-1:0] shift_up2;

        if (i == 0)
        begin : g_dn_top
            assign shift_dn = cmd.push_data;
        end
        else
        begin : g_dn_mid
            assign shift_dn = stack_reg[i-1];
        end

        if (i < sbe_pkg::STACK_DEPTH - 1)
        begin : g_up_mid
            assign shift_up = stack_reg[i+1];
        end
        else
        begin : g_up_end
            assign shift_up = stack_reg[i];
        end

        // two entries merge into the top, everything below moves up by one
        if (i == 0)
        begin : g_up2_top
            assign shift_up2 = comb_result;
        end
        else
        begin : g_up2_mid
            assign shift_up2 = shift_up;
        end

        always_comb
        begin
            if (do_push)
                stack_next[i] = shift_dn;
            else if (do_pop)
                stack_next[i] = shift_up;
            else if (do_comb)
                stack_next[i] = shift_up2;
            else
                stack_next[i] = stack_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fire)
            stack_reg <= stack_next;
    end

    always_comb
    begin
        if (do_push)
            depth_next = depth_reg + sbe_pkg::CNT_W'(1);
        else if (do_pop || do_comb)
            depth_next = depth_reg - sbe_pkg::CNT_W'(1);
        else
            depth_next = depth_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            depth_reg <= '0;
        else if (cmd.fire)
            depth_reg <= depth_next;
    end

    assign view.cur_top = stack_reg[0];
    assign view.top     = (depth_next == '0) ? '0 : stack_next[0];
    assign view.depth   = depth_next;
    assign view.status  = status;

    `SBE_ASSERT_IMPL(a_depth_bound, clk, rst_n, 1'b1, depth_reg <= sbe_pkg::CNT_W'(sbe_pkg::STACK_DEPTH))
    `SBE_ASSERT_IMPL(a_fault_holds, clk, rst_n, cmd.fire && status != sbe_pkg::ST_OK, depth_next == depth_reg)
    `SBE_ASSERT_NEXT(a_push_grows, clk, rst_n, cmd.fire && do_push, depth_reg == $past(depth_reg) + sbe_pkg::CNT_W'(1))

endmodule

/* src/stack_bytecode_executor_core.sv */
// Input beat to result beat: input register, then result register.
// One instruction per cycle unless the output stalls; stack and acc update on execute.
// An input register lets one beat be taken while a result waits on the output.
// Reset (rst_n low, asynchronous): stack empty, accumulator zero, both registers empty.
// Stack entries hold no reset value; only entries below the depth are ever read.
`include "stack_bytecode_executor_core_defines.svh"
module stack_bytecode_executor_core
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [sbe_pkg::IN_W-1:0]  s_tdata,  // func[2:0], constant_value[34:3]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [sbe_pkg::OUT_W-1:0] m_tdata   // top_value[31:0], accumulator_value[63:32],
                                                // stack_depth[68:64], status[70:69]
);

    logic                       in_valid_reg;
    sbe_pkg::func_t             func_reg;
    logic [sbe_pkg::DATA_W-1:0] const_reg;
    logic                       exec_fire;
    logic                       out_valid_reg;
    logic [sbe_pkg::OUT_W-1:0]  out_data_reg;
    logic [sbe_pkg::OUT_W-1:0]  out_data_next;
    logic [sbe_pkg::DATA_W-1:0] acc_reg;
    logic [sbe_pkg::DATA_W-1:0] acc_next;
    sbe_pkg::stack_cmd_t        cmd;
    sbe_pkg::stack_view_t       view;

    assign exec_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || exec_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            func_reg  <= sbe_pkg::func_t'(s_tdata[sbe_pkg::FUNC_W-1:0]);
            const_reg <= s_tdata[sbe_pkg::FUNC_W +: sbe_pkg::DATA_W];
        end
    end

    assign cmd.fire      = exec_fire;
    assign cmd.func      = func_reg;
    assign cmd.push_data = (func_reg == sbe_pkg::OP_PUSH_ACC) ? acc_reg : const_reg;

    sbe_stack u_stack
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .view  (view)
    );

    assign acc_next = (func_reg == sbe_pkg::OP_POP_ACC && view.status == sbe_pkg::ST_OK)
                    ? view.cur_top : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (exec_fire)
            acc_reg <= acc_next;
    end

    assign out_data_next = {1'b0, view.status, sbe_pkg::DEPTH_F_W'(view.depth), acc_next, view.top};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (exec_fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `SBE_ASSERT_NEXT(a_exec_gives_beat, clk, rst_n, exec_fire, out_valid_reg)
    `SBE_ASSERT_IMPL(a_empty_top_zero, clk, rst_n, out_valid_reg && out_data_reg[68:64] == 5'd0, out_data_reg[31:0] == '0)
    `SBE_ASSERT_IMPL(a_overflow_full, clk, rst_n, exec_fire && view.status == sbe_pkg::ST_OVERFLOW, view.depth == sbe_pkg::CNT_W'(sbe_pkg::STACK_DEPTH))

endmodule

/* tb/tb_stack_bytecode_executor_core.sv */
// Self-checking testbench for the stack bytecode executor core.
`timescale 1ns / 100ps

module tb_stack_bytecode_executor_core;

    localparam logic [sbe_pkg::FUNC_W-1:0] FUNC_RSVD5 = 3'd5;
    localparam logic [sbe_pkg::FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
    localparam logic [sbe_pkg::FUNC_W-1:0] FUNC_RSVD7 = 3'd7;
    localparam int RAND_ITEMS = 1500;
    localparam int PAUSE_AT   = 700;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_NOISE} seq_mode_t;

    typedef struct {
        logic [sbe_pkg::DATA_W-1:0]    top;
        logic [sbe_pkg::DATA_W-1:0]    acc;
        logic [sbe_pkg::DEPTH_F_W-1:0] depth;
        sbe_pkg::status_t              status;
    } exec_result_t;

    typedef struct {
        bit           typed;
        exec_result_t want;
    } beat_tag_t;

    typedef struct {
        logic [sbe_pkg::FUNC_W-1:0] fn;
        logic [sbe_pkg::DATA_W-1:0] cval;
        int                         rpt;
        bit                         typed;
        exec_result_t               want;
    } stim_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [sbe_pkg::IN_W-1:0]    s_tdata;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [sbe_pkg::OUT_W-1:0]   m_tdata;

    // shadow machine state
    logic [sbe_pkg::DATA_W-1:0]  shadow_stack [sbe_pkg::STACK_DEPTH];
    int                          shadow_cnt;
    logic [sbe_pkg::DATA_W-1:0]  shadow_acc;

    stim_row_t                   dir_tab [$];
    beat_tag_t                   tag_q [$];
    exec_result_t                result_q [$];
    int                          fail_count;
    bit                          snd_calm;
    bit                          rcv_calm;

    stack_bytecode_executor_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic exec_result_t run_instr(input logic [sbe_pkg::FUNC_W-1:0] fn,
                                               input logic [sbe_pkg::DATA_W-1:0] cval);
        exec_result_t r;
        r.status = sbe_pkg::ST_OK;
        case (fn)
            sbe_pkg::OP_PUSH_CONST, sbe_pkg::OP_PUSH_ACC:
            begin
                if (shadow_cnt >= sbe_pkg::STACK_DEPTH)
                    r.status = sbe_pkg::ST_OVERFLOW;
                else
                begin
                    shadow_stack[shadow_cnt] = (fn == sbe_pkg::OP_PUSH_CONST) ? cval
                                                                              : shadow_acc;
                    shadow_cnt++;
                end
            end
            sbe_pkg::OP_POP_ACC:
            begin
                if (shadow_cnt == 0)
                    r.status = sbe_pkg::ST_UNDERFLOW;
                else
                begin
                    shadow_cnt--;
                    shadow_acc = shadow_stack[shadow_cnt];
                end
            end
            sbe_pkg::OP_ADD, sbe_pkg::OP_MUL:
            begin
                if (shadow_cnt < 2)
                    r.status = sbe_pkg::ST_UNDERFLOW;
                else
                begin
                    if (fn == sbe_pkg::OP_ADD)
                        shadow_stack[shadow_cnt-2] = shadow_stack[shadow_cnt-1]
                                                   + shadow_stack[shadow_cnt-2];
                    else
                        shadow_stack[shadow_cnt-2] = shadow_stack[shadow_cnt-1]
                                                   * shadow_stack[shadow_cnt-2];
                    shadow_cnt--;
                end
            end
            default: ;
        endcase
        r.top   = (shadow_cnt > 0) ? shadow_stack[shadow_cnt-1] : '0;
        r.acc   = shadow_acc;
        r.depth = shadow_cnt[sbe_pkg::DEPTH_F_W-1:0];
        return r;
    endfunction

    function automatic exec_result_t mk_result(input logic [sbe_pkg::DATA_W-1:0] top,
                                               input logic [sbe_pkg::DATA_W-1:0] acc,
                                               input int depth, input sbe_pkg::status_t st);
        exec_result_t r;
        r.top    = top;
        r.acc    = acc;
        r.depth  = depth[sbe_pkg::DEPTH_F_W-1:0];
        r.status = st;
        return r;
    endfunction

    function automatic stim_row_t mk_row(input logic [sbe_pkg::FUNC_W-1:0] fn,
                                         input logic [sbe_pkg::DATA_W-1:0] cval,
                                         input int rpt,
                                         input bit typed, input exec_result_t want);
        stim_row_t row;
        row.fn    = fn;
        row.cval  = cval;
        row.rpt   = rpt;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic void append_row(input stim_row_t row);
        dir_tab = {dir_tab, row};
    endfunction

    function automatic logic [sbe_pkg::FUNC_W-1:0] pick_func(input seq_mode_t mode);
        logic [sbe_pkg::FUNC_W-1:0] fn;
        int roll;
        roll = $urandom_range(0, 9);
        case (mode)
            MODE_FILL:
                fn = (roll < 8) ? (($urandom_range(0, 3) == 0) ? sbe_pkg::OP_PUSH_ACC
                                                               : sbe_pkg::OP_PUSH_CONST)
                                : 3'($urandom_range(2, 4));
            MODE_DRAIN:
                fn = (roll < 8) ? 3'($urandom_range(2, 4)) : 3'($urandom_range(0, 1));
            MODE_MIXED:
                fn = 3'($urandom_range(0, 4));
            default:
                fn = 3'($urandom_range(0, 7));
        endcase
        return fn;
    endfunction

    function automatic logic [sbe_pkg::DATA_W-1:0] pick_const();
        logic [sbe_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = '1;
            2:       v = sbe_pkg::DATA_W'($urandom_range(0, 255));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_beat(input logic [sbe_pkg::FUNC_W-1:0] fn,
                             input logic [sbe_pkg::DATA_W-1:0] cval,
                             input bit typed, input exec_result_t want);
        int gap;
        beat_tag_t tag;
        gap = snd_calm ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tag.typed = typed;
        tag.want  = want;
        tag_q = {tag_q, tag};
        s_tvalid <= 1'b1;
        s_tdata  <= {{(sbe_pkg::IN_W-sbe_pkg::DATA_W-sbe_pkg::FUNC_W){1'b0}}, cval, fn};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic check_field(input string name, input logic [sbe_pkg::DATA_W-1:0] want,
                               input logic [sbe_pkg::DATA_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // input beats feed the shadow machine, output beats are checked in order
    always @(posedge clk)
    begin
        beat_tag_t    tag;
        exec_result_t pred;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                tag  = tag_q.pop_front();
                pred = run_instr(s_tdata[sbe_pkg::FUNC_W-1:0],
                                 s_tdata[sbe_pkg::FUNC_W+sbe_pkg::DATA_W-1:sbe_pkg::FUNC_W]);
                if (tag.typed)
                    pred = tag.want;
                result_q = {result_q, pred};
            end
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, m_tdata);
                    fail_count++;
                end
                else
                begin
                    pred = result_q.pop_front();
                    check_field("top_value", pred.top, m_tdata[31:0]);
                    check_field("accumulator_value", pred.acc, m_tdata[63:32]);
                    check_field("stack_depth", 32'(pred.depth), 32'(m_tdata[68:64]));
                    check_field("status", 32'(pred.status), 32'(m_tdata[70:69]));
                end
            end
        end
    end

    initial
    begin
        int gap;
        rcv_calm = 1'b0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rcv_calm = ~rcv_calm;
            gap = rcv_calm ? 0 : $urandom_range(0, 18);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin
        exec_result_t               none;
        seq_mode_t                  mode;
        logic [sbe_pkg::FUNC_W-1:0] fn;
        int                         sent;
        int                         seg_len;
        bit                         paused;

        fail_count = 0;
        shadow_cnt = 0;
        shadow_acc = '0;
        snd_calm   = 1'b0;
        none       = mk_result('0, '0, 0, sbe_pkg::ST_OK);
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        append_row(mk_row(sbe_pkg::OP_POP_ACC,    '0,            1, 1'b1,
                          mk_result('0, '0, 0, sbe_pkg::ST_UNDERFLOW)));
        append_row(mk_row(sbe_pkg::OP_ADD,        '1,            1, 1'b1,
                          mk_result('0, '0, 0, sbe_pkg::ST_UNDERFLOW)));
        append_row(mk_row(sbe_pkg::OP_MUL,        32'd5,         1, 1'b1,
                          mk_result('0, '0, 0, sbe_pkg::ST_UNDERFLOW)));
        append_row(mk_row(FUNC_RSVD5,             '1,            1, 1'b1,
                          mk_result('0, '0, 0, sbe_pkg::ST_OK)));
        append_row(mk_row(FUNC_RSVD7,             '0,            1, 1'b1,
                          mk_result('0, '0, 0, sbe_pkg::ST_OK)));
        append_row(mk_row(sbe_pkg::OP_PUSH_CONST, '1,            1, 1'b1,
                          mk_result('1, '0, 1, sbe_pkg::ST_OK)));
        append_row(mk_row(sbe_pkg::OP_ADD,        '0,            1, 1'b1,
                          mk_result('1, '0, 1, sbe_pkg::ST_UNDERFLOW)));
        append_row(mk_row(sbe_pkg::OP_MUL,        '1,            1, 1'b1,
                          mk_result('1, '0, 1, sbe_pkg::ST_UNDERFLOW)));
        append_row(mk_row(sbe_pkg::OP_PUSH_CONST, '1,            1, 1'b1,
                          mk_result('1, '0, 2, sbe_pkg::ST_OK)));
        append_row(mk_row(sbe_pkg::OP_ADD,        '0,            1, 1'b1,
                          mk_result(32'hFFFF_FFFE, '0, 1, sbe_pkg::ST_OK)));
        append_row(mk_row(sbe_pkg::OP_PUSH_CONST, 32'd2,         1, 1'b1,
                          mk_result(32'd2, '0, 2, sbe_pkg::ST_OK)));
        append_row(mk_row(sbe_pkg::OP_MUL,        '1,            1, 1'b1,
                          mk_result(32'hFFFF_FFFC, '0, 1, sbe_pkg::ST_OK)));
        append_row(mk_row(sbe_pkg::OP_POP_ACC,    '1,            1, 1'b1,
                          mk_result('0, 32'hFFFF_FFFC, 0, sbe_pkg::ST_OK)));
        append_row(mk_row(FUNC_RSVD6,             32'h1234,      1, 1'b1,
                          mk_result('0, 32'hFFFF_FFFC, 0, sbe_pkg::ST_OK)));
        append_row(mk_row(sbe_pkg::OP_PUSH_ACC,   '0,            1, 1'b1,
                          mk_result(32'hFFFF_FFFC, 32'hFFFF_FFFC, 1, sbe_pkg::ST_OK)));
        append_row(mk_row(sbe_pkg::OP_PUSH_CONST, '0,            1, 1'b1,
                          mk_result('0, 32'hFFFF_FFFC, 2, sbe_pkg::ST_OK)));
        append_row(mk_row(sbe_pkg::OP_MUL,        '0,            1, 1'b1,
                          mk_result('0, 32'hFFFF_FFFC, 1, sbe_pkg::ST_OK)));
        append_row(mk_row(sbe_pkg::OP_PUSH_CONST, 32'h8000_0000, 15, 1'b0, none));
        append_row(mk_row(sbe_pkg::OP_PUSH_CONST, 32'd1,         1, 1'b1,
                          mk_result(32'h8000_0000, 32'hFFFF_FFFC, 16, sbe_pkg::ST_OVERFLOW)));
        append_row(mk_row(sbe_pkg::OP_PUSH_ACC,   '0,            1, 1'b1,
                          mk_result(32'h8000_0000, 32'hFFFF_FFFC, 16, sbe_pkg::ST_OVERFLOW)));
        append_row(mk_row(sbe_pkg::OP_ADD,        '0,            1, 1'b1,
                          mk_result('0, 32'hFFFF_FFFC, 15, sbe_pkg::ST_OK)));
        append_row(mk_row(sbe_pkg::OP_MUL,        '1,            1, 1'b1,
                          mk_result('0, 32'hFFFF_FFFC, 14, sbe_pkg::ST_OK)));
        append_row(mk_row(sbe_pkg::OP_POP_ACC,    '0,            1, 1'b0, none));

        foreach (dir_tab[i])
            repeat (dir_tab[i].rpt)
                send_beat(dir_tab[i].fn, dir_tab[i].cval, dir_tab[i].typed, dir_tab[i].want);

        // random part: runs of fill, drain, mixed and noise to sweep the whole depth range
        sent   = 0;
        paused = 1'b0;
        while (sent < RAND_ITEMS)
        begin
            mode     = seq_mode_t'($urandom_range(0, 3));
            seg_len  = $urandom_range(4, 30);
            snd_calm = ($urandom_range(0, 3) == 0);
            repeat (seg_len)
            begin
                fn = pick_func(mode);
                send_beat(fn, pick_const(), 1'b0, none);
                sent++;
            end
            if (!paused && sent >= PAUSE_AT)
            begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (result_q.size() != 0) @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (result_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        if (result_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, result_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
